FILE: design/squaring_modular_random_generator_unit_defines.svh
// Assertion helpers used by the square-modulo RTL.
`ifndef SQUARING_MODULAR_RANDOM_GENERATOR_UNIT_DEFINES_SVH
`define SQUARING_MODULAR_RANDOM_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SMRG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smrg assertion failed");

// Next-cycle implication.
`define SMRG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smrg assertion failed");

`endif

FILE: design/smrg_pkg.sv
package smrg_pkg;

    localparam int MODULUS_BITS_DEF = 32;
    localparam int NUMBER_W         = 32;
    localparam int PRIME_W          = 16;
    localparam int SEED_W           = 32;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 32;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PRIME_P = 2'd0;
    localparam t_cfg_idx CFG_PRIME_Q = 2'd1;
    localparam t_cfg_idx CFG_SEED    = 2'd2;

    localparam logic [PRIME_W-1:0] PRIME_P_RST = 16'd11;
    localparam logic [PRIME_W-1:0] PRIME_Q_RST = 16'd23;
    localparam logic [SEED_W-1:0]  SEED_RST    = 32'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PREP,
        S_RED,
        S_DONE
    } t_sqmod_state;

    typedef struct packed {
        logic start;
        logic ack;
    } t_sqmod_ctl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_sqmod_sts;

endpackage

FILE: design/smrg_if.sv
interface smrg_req_if;
    import smrg_pkg::*;

    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface smrg_num_if;
    import smrg_pkg::*;

    logic                valid;
    logic                ready;
    logic [NUMBER_W-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface smrg_cfg_if;
    import smrg_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/smrg_cfg.sv
module smrg_cfg #(
    parameter int MODULUS_BITS = smrg_pkg::MODULUS_BITS_DEF,
    parameter int MW           = (MODULUS_BITS < smrg_pkg::NUMBER_W) ? MODULUS_BITS
                                                                     : smrg_pkg::NUMBER_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    smrg_cfg_if.sink                    i_cfg,
    output logic [MW-1:0]               o_modulus,
    output logic [smrg_pkg::SEED_W-1:0] o_seed
);
    import smrg_pkg::*;

    logic [PRIME_W-1:0]   r_prime_p;
    logic [PRIME_W-1:0]   r_prime_q;
    logic [SEED_W-1:0]    r_seed;
    logic [2*PRIME_W-1:0] w_prod;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime_p <= PRIME_P_RST;
            r_prime_q <= PRIME_Q_RST;
            r_seed    <= SEED_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_PRIME_P: r_prime_p <= i_cfg.data[PRIME_W-1:0];
                CFG_PRIME_Q: r_prime_q <= i_cfg.data[PRIME_W-1:0];
                CFG_SEED:    r_seed    <= i_cfg.data[SEED_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_prod    = r_prime_p * r_prime_q;
    assign o_modulus = w_prod[MW-1:0];
    assign o_seed    = r_seed;

endmodule

FILE: design/smrg_sqmod.sv
`include "squaring_modular_random_generator_unit_defines.svh"

module smrg_sqmod #(
    parameter int MW = smrg_pkg::NUMBER_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  smrg_pkg::t_sqmod_ctl          i_ctl,
    input  logic [smrg_pkg::NUMBER_W-1:0] i_base,
    input  logic [MW-1:0]                 i_modulus,
    output smrg_pkg::t_sqmod_sts          o_sts,
    output logic [smrg_pkg::NUMBER_W-1:0] o_number
);
    import smrg_pkg::*;

    localparam int SQ_W  = 2 * NUMBER_W;
    localparam int STEPS = SQ_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    t_sqmod_state        r_state;
    t_sqmod_state        n_state;
    logic [NUMBER_W-1:0] r_base;
    logic [SQ_W-1:0]     r_sq;
    logic [MW-1:0]       r_m;
    logic [MW+1:0]       r_m2;
    logic [MW+1:0]       r_m3;
    logic [MW-1:0]       r_rem;
    logic [CNT_W-1:0]    r_cnt;

    logic [MW+1:0]       w_t;
    logic [MW+1:0]       w_m1;
    logic [MW+1:0]       w_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_sts   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_sts.idle = 1'b1;
                if (i_ctl.start) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_PREP;
            S_PREP: n_state = S_RED;
            S_RED: begin
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_sts.done = 1'b1;
                if (i_ctl.ack) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // radix-4 restoring step: bring in two bits, subtract the largest multiple that fits
    assign w_t  = {r_rem, r_sq[SQ_W-1 -: 2]};
    assign w_m1 = (MW+2)'(r_m);

    always_comb begin
        priority if (w_t >= r_m3) begin
            w_diff = w_t - r_m3;
        end else if (w_t >= r_m2) begin
            w_diff = w_t - r_m2;
        end else if (w_t >= w_m1) begin
            w_diff = w_t - w_m1;
        end else begin
            w_diff = w_t;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_ctl.start) begin
                    r_base <= i_base;
                end
            end
            S_MUL: begin
                r_sq <= r_base * r_base;
                r_m  <= i_modulus;
            end
            S_PREP: begin
                r_m2  <= {1'b0, r_m, 1'b0};
                r_m3  <= {1'b0, r_m, 1'b0} + w_m1;
                r_rem <= '0;
                r_cnt <= CNT_W'(STEPS - 1);
            end
            S_RED: begin
                r_rem <= w_diff[MW-1:0];
                r_sq  <= r_sq << 2;
                r_cnt <= r_cnt - 1'b1;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    assign o_number = (r_m == '0) ? '0 : NUMBER_W'(r_rem);

    `SMRG_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_ctl.start, r_state == S_IDLE)
    `SMRG_ASSERT_NEXT(a_start_mul, i_clk, i_rst_n, i_ctl.start, r_state == S_MUL)
    `SMRG_ASSERT_IMP(a_rem_below, i_clk, i_rst_n, (r_state == S_RED) && (r_m != '0), r_rem < r_m)
    `SMRG_ASSERT_NEXT(a_done_hold, i_clk, i_rst_n, (r_state == S_DONE) && !i_ctl.ack, r_state == S_DONE)

endmodule

FILE: design/squaring_modular_random_generator_unit.sv
// channel   dir   beat fields      handshake
// i_req     in    restart          valid/ready
// o_num     out   number           valid/ready
// i_cfg     in    index, data      valid/ready, always ready
//
// A request passes from accept to result through a state for the 32x32 square,
// a state that sets up the modulus multiples, 32 radix-4 reduction steps of
// the shared compare/subtract unit, and a state that hands the result to the
// output register. No new request is taken while one is in progress. The next
// request is taken once the result sits in the output register, so a stalled
// output blocks at most one further result.
// Reset is synchronous, active low, and restores the configuration defaults.
module squaring_modular_random_generator_unit #(
    parameter int MODULUS_BITS = smrg_pkg::MODULUS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smrg_req_if.sink    i_req,
    smrg_num_if.source  o_num,
    smrg_cfg_if.sink    i_cfg
);
    import smrg_pkg::*;

    localparam int MW = (MODULUS_BITS < NUMBER_W) ? MODULUS_BITS : NUMBER_W;

    logic [MW-1:0]       w_modulus;
    logic [SEED_W-1:0]   w_seed;
    t_sqmod_ctl          w_ctl;
    t_sqmod_sts          w_sts;
    logic [NUMBER_W-1:0] w_base;
    logic [NUMBER_W-1:0] w_result;

    logic                r_started;
    logic [NUMBER_W-1:0] r_current;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [NUMBER_W-1:0] r_number;

    smrg_cfg #(
        .MODULUS_BITS (MODULUS_BITS),
        .MW           (MW)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .o_modulus (w_modulus),
        .o_seed    (w_seed)
    );

    smrg_sqmod #(
        .MW (MW)
    ) u_sqmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_base    (w_base),
        .i_modulus (w_modulus),
        .o_sts     (w_sts),
        .o_number  (w_result)
    );

    assign i_req.ready = w_sts.idle;
    assign w_ctl.start = i_req.valid && w_sts.idle;
    assign w_ctl.ack   = w_sts.done && (!r_out_valid || o_num.ready);
    assign w_base      = (i_req.restart || !r_started) ? NUMBER_W'(w_seed) : r_current;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_ctl.ack) begin
            n_out_valid = 1'b1;
        end else if (o_num.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_current   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_ctl.start) begin
                r_started <= 1'b1;
            end
            if (w_ctl.ack) begin
                r_current <= w_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.ack) begin
            r_number <= w_result;
        end
    end

    assign o_num.valid  = r_out_valid;
    assign o_num.number = r_number;

endmodule
